>>> hw/rtl/spq_pkg.sv
// Package for the sorted-insert priority queue.
// Holds capacity, derived widths, command codes and the entry and link types.
// No dependencies.
package spq_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 16;
    localparam int PRIO_W   = 8;
    localparam int INDEX_W  = 5;
    localparam int OCC_W    = 6;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef logic [CNT_W-1:0] count_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        entry_t entry;
        logic   after;
    } link_t;

endpackage

>>> hw/rtl/spq_cell.sv
// One storage cell of the priority queue chain.
// Depends on spq_pkg for entry_t and link_t.
module spq_cell (
    input  logic            aclk,
    input  logic            ins_en,
    input  logic            occupied,
    input  spq_pkg::entry_t new_entry,
    input  spq_pkg::link_t  left_link,
    output spq_pkg::link_t  right_link,
    output spq_pkg::entry_t entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            gt;
    logic            after;

    assign gt    = occupied && (entry_reg.prio > new_entry.prio);
    assign after = gt || !occupied;

    assign right_link.entry = entry_reg;
    assign right_link.after = after;
    assign entry            = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ins_en && left_link.after) begin
            entry_next = left_link.entry;
        end else if (ins_en && after) begin
            entry_next = new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

>>> hw/rtl/sorted_insert_priority_queue.sv
// Top level of the sorted-insert priority queue: a chain of spq_cell stages.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel (s_*): one beat is a command. Insert (cmd 0) places
//   item_value/item_priority in ascending priority order, after any equal
//   priorities; a full queue drops it and reports accepted = 0. Read (cmd 1)
//   returns the entry at read_index, with entry_valid clear at or beyond
//   the occupancy.
//   Result channel (m_*): one beat per command, carrying occupancy and
//   is_full after the command.
//   The result beat is registered and valid in the cycle after the command beat.
//   Throughput: one command per cycle while s_ready is high. Every cell compares the new priority
//   and shifts in the same cycle, so inserts follow each other directly.
//   A command is taken while the result register is empty or being drained.
//   Stall: while m_ready is low with a result pending, s_ready is low and
//   the result holds.
//   Reset: clears the occupancy and the result valid flag; stored entries
//   are not cleared and are unreachable until written.
module sorted_insert_priority_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [15:0] s_item_value,
    input  logic [7:0]  s_item_priority,
    input  logic [4:0]  s_read_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic        m_entry_valid,
    output logic [15:0] m_entry_value,
    output logic [7:0]  m_entry_priority,
    output logic [5:0]  m_occupancy,
    output logic        m_is_full
);

    spq_pkg::count_t count_reg;
    spq_pkg::count_t count_next;
    logic            full;
    logic            s_beat;
    logic            do_insert;
    spq_pkg::entry_t new_entry;

    logic [spq_pkg::CAPACITY-1:0] occupied;
    spq_pkg::link_t               links [spq_pkg::CAPACITY+1];
    spq_pkg::entry_t              cells [spq_pkg::CAPACITY];

    logic        m_valid_reg;
    logic        m_valid_next;
    logic        m_accepted_reg;
    logic        m_entry_valid_reg;
    logic [15:0] m_entry_value_reg;
    logic [7:0]  m_entry_priority_reg;
    logic [5:0]  m_occupancy_reg;
    logic        m_is_full_reg;

    logic        rd_valid;
    logic [15:0] rd_value;
    logic [7:0]  rd_prio;
    logic        full_next;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_beat    = s_valid && s_ready;
    assign full      = (count_reg == spq_pkg::count_t'(spq_pkg::CAPACITY));
    assign do_insert = s_beat && (s_cmd == spq_pkg::CMD_INSERT) && !full;

    assign new_entry.value = s_item_value;
    assign new_entry.prio  = s_item_priority;

    assign links[0] = '0;

    for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
        assign occupied[i] = (spq_pkg::count_t'(i) < count_reg);

        spq_cell u_cell (
            .aclk       (aclk),
            .ins_en     (do_insert),
            .occupied   (occupied[i]),
            .new_entry  (new_entry),
            .left_link  (links[i]),
            .right_link (links[i+1]),
            .entry      (cells[i])
        );
    end

    always_comb begin
        rd_valid = 1'b0;
        rd_value = '0;
        rd_prio  = '0;
        for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
            if ((32'(s_read_index) == 32'(i)) && occupied[i]) begin
                rd_valid = 1'b1;
                rd_value = cells[i].value;
                rd_prio  = cells[i].prio;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + spq_pkg::count_t'(1);
        end
    end

    assign full_next = (count_next == spq_pkg::count_t'(spq_pkg::CAPACITY));

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_beat) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            m_accepted_reg <= do_insert;
            if (s_cmd == spq_pkg::CMD_READ) begin
                m_entry_valid_reg    <= rd_valid;
                m_entry_value_reg    <= rd_value;
                m_entry_priority_reg <= rd_prio;
            end else begin
                m_entry_valid_reg    <= 1'b0;
                m_entry_value_reg    <= '0;
                m_entry_priority_reg <= '0;
            end
            m_occupancy_reg <= 6'(count_next);
            m_is_full_reg   <= full_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_accepted       = m_accepted_reg;
    assign m_entry_valid    = m_entry_valid_reg;
    assign m_entry_value    = m_entry_value_reg;
    assign m_entry_priority = m_entry_priority_reg;
    assign m_occupancy      = m_occupancy_reg;
    assign m_is_full        = m_is_full_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= spq_pkg::CAPACITY)
        else $error("occupancy beyond capacity");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> (count_reg == $past(count_reg) + spq_pkg::count_t'(1)))
        else $error("stored insert did not advance occupancy");

    a_sorted_head: assert property (@(posedge aclk) disable iff (!aresetn)
        occupied[1] |-> (cells[0].prio <= cells[1].prio))
        else $error("head cells out of order");

    a_read_not_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_entry_valid) |-> !m_accepted)
        else $error("read result flagged as stored insert");

endmodule
